[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the cavity population update block.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check a property on every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check a property including reset cycles
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

[hdl/cpu_pkg.sv]
// Package for the cavity population update block: types and constants.
// Depends on nothing.
`default_nettype none
package cpu_pkg;
  localparam logic [1:0] MODE_UPDATE = 2'd0;
  localparam logic [1:0] MODE_SAMPLE = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] CFG_ENERGY  = 2'd0;
  localparam logic [1:0] CFG_BROAD   = 2'd1;
  localparam logic [1:0] CFG_SCALE   = 2'd2;
  localparam logic signed [31:0] ONE_Q24 = 32'sd16777216;
  localparam logic signed [39:0] SUM_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] SUM_MIN = {1'b1, {39{1'b0}}};
  localparam int QW = 33;  // quotient bits kept (value capped at 2^32)

  typedef struct packed {
    logic        start;
    logic [39:0] ma;
    logic [39:0] mb;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] qa;
    logic [32:0] qb;
  } div_rsp_t;
endpackage
`default_nettype wire

[hdl/cpu_ram.sv]
// Generic single-port synchronous RAM with registered read.
// Depends on nothing.
`default_nettype none
module cpu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write or read one entry a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[hdl/cpu_recip.sv]
// Restoring divider that forms rounded |m|*2^48/D for both parts of 1/S,
// one quotient bit per cycle per part. Depends on cpu_pkg.
`default_nettype none
`include "assert_macros.svh"
module cpu_recip (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cpu_pkg::div_req_t req,
  output cpu_pkg::div_rsp_t      rsp
);
  import cpu_pkg::*;

  // Quotient >= 2^32 saturates anyway, so only low 33 bits plus overflow matter.
  // Numerator N = m*2^49 + D (below 2^89), divisor 2D. We do long division
  // over bits 127..0 but note upper quotient bits collapse into a sticky cap.
  // Squares are built from three 20x20 partial products.
  localparam int NW = 128;
  localparam int DW = 81;  // 2D fits in 81 bits
  localparam int HW = 20;  // half width of a magnitude

  logic [1:0]      phase_r, phase_nxt;   // idle, square, load, divide
  logic [6:0]      bit_r, bit_nxt;
  logic [1:0]      step_r;
  logic [39:0]     ma_r, mb_r;
  logic [79:0]     sqa_r, sqb_r;
  logic [DW-1:0]   d2_r;
  logic [NW-1:0]   na_r, nb_r;
  logic [DW:0]     ra_r, rb_r, ra_nxt, rb_nxt;
  logic [QW-1:0]   qa_r, qb_r;
  logic            capa_r, capb_r;
  logic            done_r;
  logic [DW:0]     ra_sh, rb_sh;
  logic            ra_ge, rb_ge;
  logic [HW-1:0]   opa_x, opa_y, opb_x, opb_y;
  logic [2*HW-1:0] pa, pb;
  logic [79:0]     pa_sh, pb_sh;
  logic [80:0]     dsum;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SQ   = 2'd1;
  localparam logic [1:0] PH_LD   = 2'd2;
  localparam logic [1:0] PH_DIV  = 2'd3;

  // pick the partial product of this squaring step
  always_comb begin
    opa_x = (step_r == 2'd0) ? ma_r[HW-1:0] : ma_r[2*HW-1:HW];
    opa_y = (step_r == 2'd2) ? ma_r[2*HW-1:HW] : ma_r[HW-1:0];
    opb_x = (step_r == 2'd0) ? mb_r[HW-1:0] : mb_r[2*HW-1:HW];
    opb_y = (step_r == 2'd2) ? mb_r[2*HW-1:HW] : mb_r[HW-1:0];
    pa    = opa_x * opa_y;
    pb    = opb_x * opb_y;
    unique case (step_r)
      2'd0: begin
        pa_sh = 80'(pa);
        pb_sh = 80'(pb);
      end
      2'd1: begin
        pa_sh = 80'(pa) << (HW + 1);
        pb_sh = 80'(pb) << (HW + 1);
      end
      default: begin
        pa_sh = 80'(pa) << (2 * HW);
        pb_sh = 80'(pb) << (2 * HW);
      end
    endcase
    dsum = 81'(sqa_r) + 81'(sqb_r);
  end

  // shift in next numerator bit and trial subtract
  always_comb begin
    ra_sh  = {ra_r[DW-1:0], na_r[bit_r]};
    rb_sh  = {rb_r[DW-1:0], nb_r[bit_r]};
    ra_ge  = ra_sh >= {1'b0, d2_r};
    rb_ge  = rb_sh >= {1'b0, d2_r};
    ra_nxt = ra_ge ? ra_sh - {1'b0, d2_r} : ra_sh;
    rb_nxt = rb_ge ? rb_sh - {1'b0, d2_r} : rb_sh;
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    unique case (phase_r)
      PH_IDLE: if (req.start) phase_nxt = PH_SQ;
      PH_SQ:   if (step_r == 2'd2) phase_nxt = PH_LD;
      PH_LD: begin
        phase_nxt = PH_DIV;
        bit_nxt   = 7'd127;
      end
      PH_DIV: begin
        bit_nxt = bit_r - 7'd1;
        if (bit_r == 7'd0) phase_nxt = PH_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= (phase_r == PH_DIV) && (bit_r == 7'd0);
    end
  end

  // datapath: latch, square, load, then one bit a cycle
  always_ff @(posedge clk) begin
    bit_r <= bit_nxt;
    unique case (phase_r)
      PH_IDLE: begin
        ma_r   <= req.ma;
        mb_r   <= req.mb;
        sqa_r  <= '0;
        sqb_r  <= '0;
        step_r <= 2'd0;
      end
      PH_SQ: begin
        sqa_r  <= sqa_r + pa_sh;
        sqb_r  <= sqb_r + pb_sh;
        step_r <= step_r + 2'd1;
      end
      PH_LD: begin
        d2_r   <= {dsum[79:0], 1'b0};
        na_r   <= ({88'd0, ma_r} << 49) + NW'(dsum);
        nb_r   <= ({88'd0, mb_r} << 49) + NW'(dsum);
        ra_r   <= '0;
        rb_r   <= '0;
        qa_r   <= '0;
        qb_r   <= '0;
        capa_r <= 1'b0;
        capb_r <= 1'b0;
      end
      PH_DIV: begin
        ra_r   <= ra_nxt;
        rb_r   <= rb_nxt;
        qa_r   <= {qa_r[QW-2:0], ra_ge};
        qb_r   <= {qb_r[QW-2:0], rb_ge};
        capa_r <= capa_r | qa_r[QW-1];
        capb_r <= capb_r | qb_r[QW-1];
      end
    endcase
  end

  // cap quotient at 2^32
  logic [QW-1:0] qa_cap, qb_cap;
  localparam logic [QW-1:0] QCAP = {1'b1, {(QW-1){1'b0}}};
  always_comb begin
    qa_cap = (capa_r || qa_r > QCAP) ? QCAP : qa_r;
    qb_cap = (capb_r || qb_r > QCAP) ? QCAP : qb_r;
  end

  assign rsp.done = done_r;
  assign rsp.qa   = qa_cap;
  assign rsp.qb   = qb_cap;

  `ASSERT_CLK(a_done_after_div, rsp.done |-> $past(phase_r) == PH_DIV, "done without divide")
  `ASSERT_CLK(a_no_start_busy, (phase_r != PH_IDLE) |-> !req.start, "start while dividing")
  `ASSERT_CLK(a_rem_bound, (phase_r == PH_DIV) |-> ra_r < {1'b0, d2_r} || bit_r == 7'd127,
              "remainder out of range")
endmodule
`default_nettype wire

[hdl/cavity_population_update.sv]
// Cavity population update: a term transaction holds busy after it is accepted
// (memory read, then accumulate), so a new term cannot be accepted until both
// are done. A group's last term also runs the complex reciprocal on the
// bit-serial divider (3 squaring steps, a load step and 128 quotient steps)
// before the result strobe, and busy drops in the same cycle as the strobe; a
// zero sum skips the divider. After reset a clearing pass writes 1+0i to every
// entry while busy is high. Results show for one cycle on out_valid and cannot
// be stalled. Mode 2 clears the imaginary total; mode 3 is dropped.
`default_nettype none
`include "assert_macros.svh"
module cavity_population_update #(
  parameter int POP_SIZE = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_mode,
  input  wire logic               in_first_term,
  input  wire logic               in_last_term,
  input  wire logic               in_has_neighbor,
  input  wire logic [9:0]         in_target_slot,
  input  wire logic signed [31:0] in_site_disorder,
  input  wire logic [9:0]         in_neighbor_slot,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output logic                    out_valid,
  output logic signed [31:0]      out_field_real,
  output logic signed [31:0]      out_field_imag,
  output logic signed [63:0]      out_imag_total,
  output logic                    out_was_sample,
  output logic                    out_degenerate
);
  import cpu_pkg::*;

  localparam int AW = (POP_SIZE > 1) ? $clog2(POP_SIZE) : 1;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_WAIT = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]         st_r, st_nxt;
  logic [AW:0]        clr_r;
  logic signed [31:0] energy_r;
  logic [30:0]        broad_r;
  logic [24:0]        scale_r;
  logic signed [39:0] sre_r, sim_r;
  logic [9:0]         tgt_r;
  logic signed [63:0] tot_r;
  logic [1:0]         mode_r;
  logic               nb_ok_r, last_r;
  logic signed [31:0] fr_r, fi_r;
  logic               degen_r;
  logic               zden_r;
  logic signed [57:0] pre_r, pim_r;

  // memory port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [63:0]   ram_wdata, ram_rdata;

  cpu_ram #(.WIDTH(64), .DEPTH(POP_SIZE)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  div_req_t dreq;
  div_rsp_t drsp;
  cpu_recip u_recip (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic accept;
  assign busy   = (st_r != ST_IDLE);
  assign accept = start && !busy;

  // magnitudes of the sum
  logic [39:0] ma, mb;
  logic        zero_c;
  assign ma = sre_r[39] ? 40'(-sre_r) : 40'(sre_r);
  assign mb = sim_r[39] ? 40'(-sim_r) : 40'(sim_r);
  assign zero_c = (sre_r == '0) && (sim_r == '0);
  assign dreq.start = (st_r == ST_DIV) && !zero_c;
  assign dreq.ma    = ma;
  assign dreq.mb    = mb;

  // rounded scaled neighbor terms
  logic signed [57:0] rre, rim;
  logic signed [39:0] tre, tim;
  logic signed [40:0] dre, dim;
  always_comb begin
    rre = pre_r + 58'sd8388608;
    rim = pim_r + 58'sd8388608;
    tre = 40'(rre >>> 24);
    tim = 40'(rim >>> 24);
    dre = 41'(sre_r) - 41'(tre);
    dim = 41'(sim_r) - 41'(tim);
  end

  function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
    if (v > 41'(SUM_MAX)) return SUM_MAX;
    if (v < 41'(SUM_MIN)) return SUM_MIN;
    return 40'(v);
  endfunction

  // signed result parts
  logic signed [31:0] fr_c, fi_c;
  logic               sat_c;
  always_comb begin
    sat_c  = 1'b0;
    if (sre_r[39]) begin
      if (drsp.qa > 33'd2147483648) begin sat_c = 1'b1; fr_c = 32'sh80000000; end
      else fr_c = 32'(-$signed({1'b0, drsp.qa}));
    end else begin
      if (drsp.qa > 33'd2147483647) begin sat_c = 1'b1; fr_c = 32'sh7fffffff; end
      else fr_c = 32'(drsp.qa);
    end
    if (!sim_r[39] && sim_r != '0) begin
      if (drsp.qb > 33'd2147483648) begin sat_c = 1'b1; fi_c = 32'sh80000000; end
      else fi_c = 32'(-$signed({1'b0, drsp.qb}));
    end else begin
      if (drsp.qb > 33'd2147483647) begin sat_c = 1'b1; fi_c = 32'sh7fffffff; end
      else fi_c = 32'(drsp.qb);
    end
  end

  // saturating total update
  logic signed [64:0] tot_sum;
  logic signed [63:0] tot_new;
  always_comb begin
    tot_sum = 65'(tot_r) + 65'(fi_r);
    if (tot_sum > 65'sh0_7fff_ffff_ffff_ffff) tot_new = 64'sh7fff_ffff_ffff_ffff;
    else if (tot_sum < -65'sh0_8000_0000_0000_0000) tot_new = 64'sh8000_0000_0000_0000;
    else tot_new = 64'(tot_sum);
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLR:  if (clr_r == (AW+1)'(POP_SIZE - 1)) st_nxt = ST_IDLE;
      ST_IDLE: if (accept && (in_mode == MODE_UPDATE || in_mode == MODE_SAMPLE))
                 st_nxt = ST_RD;
      ST_RD:   st_nxt = ST_ACC;
      ST_ACC:  st_nxt = last_r ? ST_DIV : ST_IDLE;
      ST_DIV:  st_nxt = zero_c ? ST_OUT : ST_WAIT;
      ST_WAIT: if (drsp.done) st_nxt = ST_OUT;
      ST_OUT:  st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // memory access: clear sweep, neighbor read, target write
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = AW'(in_neighbor_slot);
    ram_wdata = {32'd0, ONE_Q24};
    if (st_r == ST_CLR) begin
      ram_we   = 1'b1;
      ram_addr = clr_r[AW-1:0];
    end else if (st_r == ST_OUT && !zden_r && mode_r == MODE_UPDATE &&
                 32'(tgt_r) < POP_SIZE) begin
      ram_we    = 1'b1;
      ram_addr  = AW'(tgt_r);
      ram_wdata = {fi_r, fr_r};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_CLR;
      clr_r    <= '0;
      energy_r <= '0;
      broad_r  <= 31'd167772;
      scale_r  <= 25'd9686330;
      tot_r    <= '0;
      sre_r    <= '0;
      sim_r    <= '0;
      tgt_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      out_valid <= 1'b0;
      if (st_r == ST_CLR) clr_r <= clr_r + 1'b1;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENERGY: energy_r <= cfg_data;
          CFG_BROAD:  broad_r  <= cfg_data[30:0];
          CFG_SCALE:  scale_r  <= cfg_data[24:0];
          default: ;
        endcase
      end
      if (accept && in_mode == MODE_CLEAR) tot_r <= '0;
      if (accept && (in_mode == MODE_UPDATE || in_mode == MODE_SAMPLE) &&
          in_first_term) begin
        tgt_r <= in_target_slot;
        sre_r <= 40'(in_site_disorder) - 40'(energy_r);
        sim_r <= 40'(broad_r);
      end
      if (st_r == ST_ACC && nb_ok_r) begin
        sre_r <= sat40(dre);
        sim_r <= sat40(dim);
      end
      if (st_r == ST_OUT) begin
        out_valid <= 1'b1;
        if (mode_r == MODE_SAMPLE && !zden_r) tot_r <= tot_new;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_mode;
      last_r  <= in_last_term;
      nb_ok_r <= in_has_neighbor && (32'(in_neighbor_slot) < POP_SIZE);
    end
    if (st_r == ST_RD) begin
      pre_r <= 58'($signed(ram_rdata[31:0]) * $signed({1'b0, scale_r}));
      pim_r <= 58'($signed(ram_rdata[63:32]) * $signed({1'b0, scale_r}));
    end
    if (st_r == ST_ACC) begin
      fr_r    <= '0;
      fi_r    <= '0;
      degen_r <= 1'b1;
      zden_r  <= 1'b1;
    end
    if (st_r == ST_WAIT && drsp.done) begin
      fr_r    <= fr_c;
      fi_r    <= fi_c;
      degen_r <= sat_c;
      zden_r  <= 1'b0;
    end
    if (st_r == ST_OUT) begin
      out_field_real <= fr_r;
      out_field_imag <= fi_r;
      out_imag_total <= (mode_r == MODE_SAMPLE && !zden_r) ? tot_new : tot_r;
      out_was_sample <= (mode_r == MODE_SAMPLE);
      out_degenerate <= degen_r;
    end
  end

  `ASSERT_CLK(a_out_after_out, out_valid |-> $past(st_r) == ST_OUT, "result without group end")
  `ASSERT_CLK(a_no_write_busy, ram_we |-> (st_r == ST_CLR || st_r == ST_OUT), "stray write")
  `ASSERT_CLK(a_accept_idle, accept |=> st_r == ST_RD || st_r == ST_IDLE, "bad accept")
endmodule
`default_nettype wire
